### hw/rtl/qte_pkg.sv
package qte_pkg;

  // field and datapath widths
  localparam int COMPONENT_WIDTH = 16;
  localparam int CORDIC_STEPS    = 16;
  localparam int Q15_W   = 16;
  localparam int PROD_W  = 32;
  localparam int FORM_W  = 35;
  localparam int CORD_W  = 37;
  localparam int ANG_W   = 34;
  localparam int RND_W   = ANG_W - 16;
  localparam int ROOT_W  = 31;
  localparam int RAD_W   = 61;
  localparam int THR_W   = 15;
  localparam int ANGLE_W = 16;

  // pipeline depth
  localparam int SQRT_STAGES = ROOT_W;
  localparam int CORDIC_LAT  = CORDIC_STEPS + 1;
  localparam int FRONT_LAT   = 4;
  localparam int PIPE_DEPTH  = FRONT_LAT + SQRT_STAGES + CORDIC_LAT + 1;

  localparam int ONE_Q30 = 1 << 30;
  localparam int PITCH_MAX = 16384;

  typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
  typedef logic signed [FORM_W-1:0] form_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
  } quat_t;

  // rescale one component to q1.15
  function automatic logic signed [Q15_W-1:0] to_q15(input comp_t v);
    logic signed [63:0] t;
    t = 64'(v);
    if (COMPONENT_WIDTH >= Q15_W) begin
      t = t >>> (COMPONENT_WIDTH >= Q15_W ? COMPONENT_WIDTH - Q15_W : 0);
    end else begin
      t = t <<< (COMPONENT_WIDTH < Q15_W ? Q15_W - COMPONENT_WIDTH : 0);
    end
    return t[Q15_W-1:0];
  endfunction

  // arctangent of 2^-i, 2^31 equals pi
  function automatic logic signed [ANG_W-1:0] atan_lut(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return ANG_W'(v);
  endfunction

endpackage

### hw/rtl/qte_quat_if.sv
interface qte_quat_if;
  logic                valid;
  logic                ready;
  qte_pkg::comp_t      quat_x;
  qte_pkg::comp_t      quat_y;
  qte_pkg::comp_t      quat_z;
  qte_pkg::comp_t      quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

### hw/rtl/qte_euler_if.sv
interface qte_euler_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [qte_pkg::ANGLE_W-1:0]      pitch_angle;
  logic signed [qte_pkg::ANGLE_W-1:0]      yaw_angle;
  logic signed [qte_pkg::ANGLE_W-1:0]      roll_angle;
  logic                                    gimbal_locked;

  modport source (output valid, pitch_angle, yaw_angle, roll_angle, gimbal_locked,
                  input ready);
  modport sink (input valid, pitch_angle, yaw_angle, roll_angle, gimbal_locked,
                output ready);
endinterface

### hw/rtl/quaternion_to_euler_unit.sv
// an item passes the front stages, the square root, the cordic stages and the output register in turn
// throughput: one item per cycle while the output is not stalled; the 31-stage square root
//   and the cordic stages set the depth, every stage advances together
// a one-item input skid keeps the input side registered during output stalls
// reset clears all valid bits and sets lock_threshold to 32767
module quaternion_to_euler_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [qte_pkg::THR_W-1:0]  cfg_wdata_i,
  qte_quat_if.sink                   quat_i,
  qte_euler_if.source                euler_o
);
  import qte_pkg::*;

  typedef struct packed {
    form_t               yaw_y;
    form_t               yaw_x;
    form_t               roll_y;
    form_t               roll_x;
    logic signed [31:0]  sx;
  } side_t;

  logic [THR_W-1:0]       thr_q;
  logic [PIPE_DEPTH-1:0]  vld_q;
  logic                   adv;
  logic                   skid_vld_q;
  quat_t                  skid_q, in_item, src;
  logic                   src_vld;

  // lock threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(32767);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // whole pipeline moves when the output register is free
  assign adv          = !vld_q[PIPE_DEPTH-1] || euler_o.ready;
  assign quat_i.ready = !skid_vld_q;
  assign in_item      = '{x: quat_i.quat_x, y: quat_i.quat_y,
                          z: quat_i.quat_z, w: quat_i.quat_w};
  assign src          = skid_vld_q ? skid_q : in_item;
  assign src_vld      = skid_vld_q || quat_i.valid;

  // input skid holds one item during a stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (adv) begin
      skid_vld_q <= 1'b0;
    end else if (quat_i.valid && quat_i.ready) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && quat_i.valid && quat_i.ready) begin
      skid_q <= in_item;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], src_vld};
    end
  end

  // stage 1: component products
  logic signed [Q15_W-1:0] qx, qy, qz, qw;
  prod_t p_xw_q, p_yz_q, p_xz_q, p_yw_q, p_ww_q, p_zz_q, p_xy_q, p_zw_q, p_xx_q, p_yy_q;

  assign qx = to_q15(src.x);
  assign qy = to_q15(src.y);
  assign qz = to_q15(src.z);
  assign qw = to_q15(src.w);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_xw_q <= PROD_W'(qx * qw);
      p_yz_q <= PROD_W'(qy * qz);
      p_xz_q <= PROD_W'(qx * qz);
      p_yw_q <= PROD_W'(qy * qw);
      p_ww_q <= PROD_W'(qw * qw);
      p_zz_q <= PROD_W'(qz * qz);
      p_xy_q <= PROD_W'(qx * qy);
      p_zw_q <= PROD_W'(qz * qw);
      p_xx_q <= PROD_W'(qx * qx);
      p_yy_q <= PROD_W'(qy * qy);
    end
  end

  // stage 2: quadratic forms
  form_t sx_raw_q, yn_y_q, yn_x_q, yl_y_q, yl_x_q, r_y_q, r_x_q;
  form_t one_f;

  assign one_f = FORM_W'(ONE_Q30);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_raw_q <= (FORM_W'(p_xw_q) - FORM_W'(p_yz_q)) <<< 1;
      yn_y_q   <= (FORM_W'(p_xz_q) + FORM_W'(p_yw_q)) <<< 1;
      yn_x_q   <= ((FORM_W'(p_ww_q) + FORM_W'(p_zz_q)) <<< 1) - one_f;
      yl_y_q   <= (FORM_W'(p_yw_q) - FORM_W'(p_xz_q)) <<< 1;
      yl_x_q   <= ((FORM_W'(p_ww_q) + FORM_W'(p_xx_q)) <<< 1) - one_f;
      r_y_q    <= (FORM_W'(p_xy_q) + FORM_W'(p_zw_q)) <<< 1;
      r_x_q    <= ((FORM_W'(p_ww_q) + FORM_W'(p_yy_q)) <<< 1) - one_f;
    end
  end

  // stage 3: saturate sx, detect lock, pick the yaw formula
  form_t              sx_sat;
  logic signed [31:0] sx_mag;
  logic               lock_d;
  side_t              s3_q;
  logic               lock3_q;

  always_comb begin
    if (sx_raw_q > one_f) begin
      sx_sat = one_f;
    end else if (sx_raw_q < -one_f) begin
      sx_sat = -one_f;
    end else begin
      sx_sat = sx_raw_q;
    end
    sx_mag = sx_sat[FORM_W-1] ? 32'(-sx_sat) : 32'(sx_sat);
    lock_d = sx_mag >= {2'b00, thr_q, 15'b0};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q.sx     <= 32'(sx_sat);
      s3_q.yaw_y  <= lock_d ? yl_y_q : yn_y_q;
      s3_q.yaw_x  <= lock_d ? yl_x_q : yn_x_q;
      s3_q.roll_y <= r_y_q;
      s3_q.roll_x <= r_x_q;
      lock3_q     <= lock_d;
    end
  end

  // stage 4: sx squared
  logic signed [63:0] sq_full;
  logic [RAD_W-1:0]   sq_q;
  side_t              s4_q;
  logic               lock4_q;

  assign sq_full = s3_q.sx * s3_q.sx;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q    <= sq_full[RAD_W-1:0];
      s4_q    <= s3_q;
      lock4_q <= lock3_q;
    end
  end

  // cosine of pitch by integer square root
  logic [ROOT_W-1:0] root;

  qte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .sq_i   (sq_q),
    .root_o (root)
  );

  // side data delayed to meet the root
  side_t dly_q      [SQRT_STAGES];
  logic  lock_dly_q [SQRT_STAGES + CORDIC_LAT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dly_q[0]      <= s4_q;
      lock_dly_q[0] <= lock4_q;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
      for (int k = 1; k < SQRT_STAGES + CORDIC_LAT; k++) begin
        lock_dly_q[k] <= lock_dly_q[k-1];
      end
    end
  end

  // three angle units in parallel
  side_t                  sd;
  logic signed [RND_W-1:0] pitch_a, yaw_a, roll_a;

  assign sd = dly_q[SQRT_STAGES-1];

  qte_cordic u_pitch (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (FORM_W'(sd.sx)),
    .x_i   (FORM_W'(root)),
    .ang_o (pitch_a)
  );

  qte_cordic u_yaw (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (sd.yaw_y),
    .x_i   (sd.yaw_x),
    .ang_o (yaw_a)
  );

  qte_cordic u_roll (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (sd.roll_y),
    .x_i   (sd.roll_x),
    .ang_o (roll_a)
  );

  // output register: clamp pitch, wrap angles, zero roll when locked
  logic                      lock_out;
  logic signed [ANGLE_W-1:0] pitch_d;

  assign lock_out = lock_dly_q[SQRT_STAGES + CORDIC_LAT - 1];

  always_comb begin
    if (pitch_a > RND_W'(PITCH_MAX)) begin
      pitch_d = ANGLE_W'(PITCH_MAX);
    end else if (pitch_a < -RND_W'(PITCH_MAX)) begin
      pitch_d = -ANGLE_W'(PITCH_MAX);
    end else begin
      pitch_d = pitch_a[ANGLE_W-1:0];
    end
  end

  logic signed [ANGLE_W-1:0] pitch_q, yaw_q, roll_q;
  logic                      lock_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pitch_q <= pitch_d;
      yaw_q   <= yaw_a[ANGLE_W-1:0];
      roll_q  <= lock_out ? '0 : roll_a[ANGLE_W-1:0];
      lock_q  <= lock_out;
    end
  end

  assign euler_o.valid         = vld_q[PIPE_DEPTH-1];
  assign euler_o.pitch_angle   = pitch_q;
  assign euler_o.yaw_angle     = yaw_q;
  assign euler_o.roll_angle    = roll_q;
  assign euler_o.gimbal_locked = lock_q;

endmodule

### hw/rtl/qte_isqrt.sv
module qte_isqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [qte_pkg::RAD_W-1:0]   sq_i,
  output logic [qte_pkg::ROOT_W-1:0]  root_o
);
  import qte_pkg::*;

  localparam int NW = RAD_W + 1;

  logic [NW-1:0] n_q   [SQRT_STAGES];
  logic [NW-1:0] r_q   [SQRT_STAGES];
  logic [NW-1:0] n_src [SQRT_STAGES];
  logic [NW-1:0] r_src [SQRT_STAGES];

  // radicand is one minus sx squared in q2.60
  assign n_src[0] = (NW'(1) << (2 * (SQRT_STAGES - 1))) - NW'(sq_i);
  assign r_src[0] = '0;

  // one root bit per stage
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (SQRT_STAGES - 1 - k));
    logic [NW-1:0] trial;

    if (k > 0) begin : g_link
      assign n_src[k] = n_q[k-1];
      assign r_src[k] = r_q[k-1];
    end

    assign trial = r_src[k] + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (n_src[k] >= trial) begin
          n_q[k] <= n_src[k] - trial;
          r_q[k] <= (r_src[k] >> 1) + BIT;
        end else begin
          n_q[k] <= n_src[k];
          r_q[k] <= r_src[k] >> 1;
        end
      end
    end
  end

  assign root_o = r_q[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

### hw/rtl/qte_cordic.sv
module qte_cordic (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  qte_pkg::form_t                   y_i,
  input  qte_pkg::form_t                   x_i,
  output logic signed [qte_pkg::RND_W-1:0] ang_o
);
  import qte_pkg::*;

  logic signed [CORD_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CORD_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0]  z_q [CORDIC_STEPS+1];
  logic                     zero_q [CORDIC_STEPS+1];

  logic signed [CORD_W-1:0] xe, ye, x0, y0;
  logic signed [ANG_W-1:0]  z0, rnd;

  // fold the left half plane onto the right
  always_comb begin
    xe = CORD_W'(x_i);
    ye = CORD_W'(y_i);
    if (xe < 0) begin
      if (ye >= 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = ANG_W'(ONE_Q30);
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -ANG_W'(ONE_Q30);
      end
    end else begin
      x0 = xe;
      y0 = ye;
      z0 = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0;
      y_q[0]    <= y0;
      z_q[0]    <= z0;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  // vectoring iterations, one per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (!y_q[i][CORD_W-1]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_lut(i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_lut(i);
        end
      end
    end
  end

  // round half up to the 16-bit binary angle scale
  assign rnd   = z_q[CORDIC_STEPS] + ANG_W'(32768);
  assign ang_o = zero_q[CORDIC_STEPS] ? '0 : rnd[ANG_W-1:16];

endmodule
